[rtl/pqdc_pkg.sv]
package pqdc_pkg;

    // Fixed-point format of the incoming samples
    localparam int FRAC_BITS    = 28;
    localparam int NUM_CHANNELS = 2;

    // Channel index width, at least one bit
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Working width: sample plus three feedback taps plus rounding and noise
    localparam int SW = 36;

    // Widest discarded field (8-bit output) and the shift amount width
    localparam int NZ_W = FRAC_BITS - 7;
    localparam int SH_W = 5;

    // Field widths of the block's ports
    localparam int SAMPLE_W = 32;
    localparam int WORD_W   = 32;
    localparam int ERR_W    = 32;
    localparam int CNT_W    = 32;
    localparam int PEAK_W   = FRAC_BITS + 1;
    localparam int PEAKO_W  = 29;
    localparam int EXC_W    = 31;

    // Clip limits: [-1, 1 - 2^-FRAC_BITS]
    localparam logic signed [SW-1:0] CLIP_HI = SW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [SW-1:0] CLIP_LO = -CLIP_HI - SW'(1);

    // Saturation limits
    localparam logic [EXC_W-1:0]     EXC_MAX   = {EXC_W{1'b1}};
    localparam logic signed [SW-1:0] EXC_MAX_W = SW'(EXC_MAX);
    localparam logic signed [SW-1:0] ERR_MAX_W = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] ERR_MIN_W = -ERR_MAX_W - SW'(1);

    // Noise generator constants
    localparam logic [31:0] LCG_MUL = 32'h0019660d;
    localparam logic [31:0] LCG_ADD = 32'h3c6ef35f;

    // Offset for the 8-bit offset binary format
    localparam logic [7:0] OFFSET_8 = 8'h80;

    // Register map (word index)
    localparam logic REG_RESOLUTION = 1'b0;
    localparam logic REG_DITHER     = 1'b1;

    typedef enum logic [1:0] {
        RES_8  = 2'd0,
        RES_16 = 2'd1,
        RES_24 = 2'd2,
        RES_32 = 2'd3
    } t_res;

    // Number of fraction bits dropped by the quantizer
    function automatic logic [SH_W-1:0] quant_shift(input t_res rc);
        logic [SH_W-1:0] sh;
        case (rc)
            RES_8:   sh = SH_W'(FRAC_BITS - 7);
            RES_16:  sh = SH_W'(FRAC_BITS - 15);
            default: sh = SH_W'(FRAC_BITS - 23);
        endcase
        return sh;
    endfunction

endpackage

[rtl/pcm_quantize_dither_clip.sv]
// PCM quantizer with optional noise-shaped dither and clip/peak tracking.
//
// Input channel: i_in_valid / o_in_stall carry one sample beat (sample, channel
// tag, block end mark). Output channel: o_out_valid / i_out_stall carry one
// result beat (packed PCM word, tags, clip flag and the running clip count,
// peak level and peak excess after this sample).
// A beat moves at a rising edge with valid high and stall low.
//
// The result of a sample held in the input register is loaded into the output
// register when that register is empty or its beat is taken, and is then offered
// as the result beat. One sample is taken per cycle while the receiver does not
// stall: the per-channel dither state and the shared clip statistics are
// read and written within the single compute stage, so back-to-back samples
// of the same channel need no bubbles. The noise generator runs one step
// ahead in a register, keeping its multiplier off the sample path.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more sample; o_in_stall rises only when both are
// full and the output is stalled.
// Reset (synchronous, active low) empties both stages, resets all dither state,
// clears the statistics, and sets 16-bit output with plain rounding.
// Registers: byte 0 resolution code, byte 4 dither enable.
module pcm_quantize_dither_clip
    import pqdc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_channel,
    input  logic                       i_block_end,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [WORD_W-1:0]          o_pcm_word,
    output logic                       o_channel_out,
    output logic                       o_block_end_out,
    output logic                       o_was_clipped,
    output logic [CNT_W-1:0]           o_clip_total,
    output logic [PEAKO_W-1:0]         o_peak_level,
    output logic [EXC_W-1:0]           o_peak_excess,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // Configuration
    t_res r_res;
    logic r_dither;

    // Input stage
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_ch;
    logic                       r_be;

    // Output stage
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_ch_out;
    logic              r_be_out;
    logic              r_clipped;

    // Per-channel dither state
    logic signed [ERR_W-1:0] r_err_now  [NUM_CHANNELS];
    logic signed [ERR_W-1:0] r_err_prev [NUM_CHANNELS];
    logic signed [ERR_W-1:0] r_err_old  [NUM_CHANNELS];
    logic [NZ_W-1:0]         r_seed     [NUM_CHANNELS];
    logic [NZ_W-1:0]         r_rnd      [NUM_CHANNELS];

    // Shared statistics
    logic [CNT_W-1:0]  r_clip_cnt;
    logic [PEAK_W-1:0] r_peak;
    logic [EXC_W-1:0]  r_exc;

    // Handshake
    logic w_adv;
    logic w_accept;
    logic w_load;
    logic w_cfg_wr;

    // Datapath
    logic [CH_W-1:0]        w_ch;
    logic [SH_W-1:0]        w_sh;
    logic signed [SW-1:0]   w_half;
    logic [SW-1:0]          w_low_mask;
    logic [NZ_W-1:0]        w_nz_mask;
    logic signed [SW-1:0]   w_s_raw;
    logic signed [SW-1:0]   w_fb;
    logic signed [SW-1:0]   w_s;
    logic signed [SW-1:0]   w_noise;
    logic signed [SW-1:0]   w_v;
    logic signed [SW-1:0]   w_pk;
    logic                   w_ge;
    logic                   w_lt;
    logic                   w_over;
    logic                   w_under;
    logic                   w_clipped;
    logic signed [SW-1:0]   w_vc;
    logic signed [SW-1:0]   w_vq;
    logic signed [SW-1:0]   w_e;
    logic signed [SW-1:0]   w_sc;
    logic signed [SW-1:0]   w_err;
    logic [WORD_W-1:0]      w_word;
    logic signed [ERR_W-1:0] w_now_half;
    logic [2*NZ_W-1:0]      w_prod;

    logic [CNT_W-1:0]        n_clip_cnt;
    logic [PEAK_W-1:0]       n_peak;
    logic [EXC_W-1:0]        n_exc;
    logic signed [ERR_W-1:0] n_err_now;
    logic [NZ_W-1:0]         n_rnd;

    // Handshake: output moves when empty or taken, input follows it
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_load     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // APB register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= RES_16;
            r_dither <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_RESOLUTION: r_res    <= t_res'(pwdata[1:0]);
                REG_DITHER:     r_dither <= pwdata[0];
                default:        r_dither <= r_dither;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RESOLUTION: prdata = {30'b0, r_res};
            REG_DITHER:     prdata = {31'b0, r_dither};
            default:        prdata = '0;
        endcase
    end

    // Valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample_in;
            r_ch     <= i_channel;
            r_be     <= i_block_end;
        end
    end

    // Add feedback and noise when dithering, then round
    always_comb begin
        w_ch       = (int'(r_ch) >= NUM_CHANNELS) ? CH_W'(NUM_CHANNELS - 1) : CH_W'(r_ch);
        w_sh       = quant_shift(r_res);
        w_half     = SW'(1) <<< (w_sh - SH_W'(1));
        w_low_mask = (SW'(1) << w_sh) - SW'(1);
        w_nz_mask  = NZ_W'(w_low_mask);
        w_s_raw    = SW'(r_sample);
        w_fb       = SW'(r_err_now[w_ch]) - SW'(r_err_prev[w_ch]) + SW'(r_err_old[w_ch]);
        w_noise    = $signed(SW'(r_rnd[w_ch] & w_nz_mask))
                   - $signed(SW'(r_seed[w_ch] & w_nz_mask));
        w_s        = r_dither ? (w_s_raw + w_fb) : w_s_raw;
        w_v        = w_s + w_half + (r_dither ? w_noise : SW'(0));
    end

    // Clip, count clips and track the shared peaks
    always_comb begin
        w_pk      = $signed(SW'(r_peak));
        w_ge      = (w_v >= w_pk);
        w_lt      = (w_v < -w_pk);
        w_over    = (w_v > CLIP_HI);
        w_under   = (w_v < CLIP_LO);
        w_clipped = w_over || w_under;
        w_vc      = w_over ? CLIP_HI : (w_under ? CLIP_LO : w_v);
        w_e       = w_over ? (w_v - CLIP_HI) : (CLIP_LO - w_v);

        n_clip_cnt = w_clipped ? (r_clip_cnt + CNT_W'(1)) : r_clip_cnt;
        if (w_ge) begin
            n_peak = PEAK_W'(w_vc);
        end else if (w_lt) begin
            n_peak = PEAK_W'(-w_vc);
        end else begin
            n_peak = r_peak;
        end
        if (w_clipped && (w_e > $signed(SW'(r_exc)))) begin
            n_exc = (w_e > EXC_MAX_W) ? EXC_MAX : EXC_W'(w_e);
        end else begin
            n_exc = r_exc;
        end
    end

    // Quantize and pack the word
    always_comb begin
        w_vq = w_vc >>> w_sh;
        case (r_res)
            RES_8:   w_word = {24'b0, w_vq[7:0] ^ OFFSET_8};
            RES_16:  w_word = {16'b0, w_vq[15:0]};
            RES_24:  w_word = {8'b0, w_vq[23:0]};
            default: w_word = {w_vq[23:0], 8'b0};
        endcase
    end

    // Next shaping error and the noise generator step
    always_comb begin
        if (w_clipped) begin
            w_sc = (w_s > CLIP_HI) ? CLIP_HI : ((w_s < CLIP_LO) ? CLIP_LO : w_s);
        end else begin
            w_sc = w_s;
        end
        w_err = w_sc - (w_vc & $signed(~w_low_mask));
        if (w_err > ERR_MAX_W) begin
            n_err_now = ERR_W'(ERR_MAX_W);
        end else if (w_err < ERR_MIN_W) begin
            n_err_now = ERR_W'(ERR_MIN_W);
        end else begin
            n_err_now = ERR_W'(w_err);
        end
        // Halve toward zero
        w_now_half = (r_err_now[w_ch] + $signed(ERR_W'(r_err_now[w_ch][ERR_W-1]))) >>> 1;
        w_prod     = r_rnd[w_ch] * NZ_W'(LCG_MUL);
        n_rnd      = NZ_W'(w_prod) + NZ_W'(LCG_ADD);
    end

    // Update dither state (while dithering) and statistics as the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_err_now[i]  <= '0;
                r_err_prev[i] <= '0;
                r_err_old[i]  <= '0;
                r_seed[i]     <= '0;
                r_rnd[i]      <= NZ_W'(LCG_ADD);
            end
            r_clip_cnt <= '0;
            r_peak     <= '0;
            r_exc      <= '0;
        end else if (w_load) begin
            if (r_dither) begin
                r_err_now[w_ch]  <= n_err_now;
                r_err_prev[w_ch] <= w_now_half;
                r_err_old[w_ch]  <= r_err_prev[w_ch];
                r_seed[w_ch]     <= r_rnd[w_ch];
                r_rnd[w_ch]      <= n_rnd;
            end
            r_clip_cnt <= n_clip_cnt;
            r_peak     <= n_peak;
            r_exc      <= n_exc;
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word    <= w_word;
            r_ch_out  <= r_ch;
            r_be_out  <= r_be;
            r_clipped <= w_clipped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pcm_word      = r_word;
    assign o_channel_out   = r_ch_out;
    assign o_block_end_out = r_be_out;
    assign o_was_clipped   = r_clipped;
    assign o_clip_total    = r_clip_cnt;
    assign o_peak_level    = PEAKO_W'(r_peak);
    assign o_peak_excess   = r_exc;

`ifndef SYNTHESIS
    // Upstream is held off only when both stages are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a stage is free");

    // Peak level never exceeds unity
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= PEAK_W'(CLIP_HI + SW'(1)))
        else $error("peak level beyond unity");

    // Clip count moves by at most one per cycle
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_clip_cnt == $past(r_clip_cnt)
                            || r_clip_cnt == $past(r_clip_cnt) + CNT_W'(1)))
        else $error("clip count jumped");

    // A clipped sample bumps the count
    a_cnt_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_load && w_clipped))
            |-> (r_clip_cnt == $past(r_clip_cnt) + CNT_W'(1)))
        else $error("clipped sample not counted");
`endif

endmodule

[bench/tb_top.sv]
module tb_top;
    import pqdc_pkg::*;

    localparam longint CLIP_TOP = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam longint CLIP_BOT = -(64'sd1 <<< FRAC_BITS);
    localparam longint ERR_TOP  = 64'sd2147483647;
    localparam longint ERR_BOT  = -64'sd2147483648;
    localparam longint EXC_TOP  = 64'sd2147483647;
    localparam int     HOLD_CYCLES    = 60;
    localparam int     PHASES         = 8;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam int     DIRECTED_ROWS  = 23;

    // One result beat as the block presents it
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               ch;
        logic               be;
        logic               clip;
        logic [CNT_W-1:0]   total;
        logic [PEAKO_W-1:0] peak;
        logic [EXC_W-1:0]   excess;
    } pcm_beat_t;

    // One directed sample; word and clip are hand values where typed is set
    typedef struct packed {
        t_res        res;
        logic        dith;
        logic [31:0] smp;
        logic        ch;
        logic        be;
        logic        typed;
        logic [31:0] word;
        logic        clip;
    } stim_row_t;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       i_channel   = 1'b0;
    logic                       i_block_end = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [WORD_W-1:0]          o_pcm_word;
    logic                       o_channel_out;
    logic                       o_block_end_out;
    logic                       o_was_clipped;
    logic [CNT_W-1:0]           o_clip_total;
    logic [PEAKO_W-1:0]         o_peak_level;
    logic [EXC_W-1:0]           o_peak_excess;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [2:0]                 paddr       = '0;
    logic [31:0]                pwdata      = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Shadow of the block's configuration and dither/statistics state
    t_res        cur_res  = RES_16;
    logic        cur_dith = 1'b0;
    longint      err_now [2] = '{0, 0};
    longint      err_prev[2] = '{0, 0};
    longint      err_old [2] = '{0, 0};
    logic [31:0] noise_seed[2] = '{32'd0, 32'd0};
    logic [31:0] clip_cnt = '0;
    longint      pk_lvl   = 0;
    longint      exc_pk   = 0;

    pcm_beat_t   pending_pcm[$];
    stim_row_t   directed_rows[DIRECTED_ROWS];
    int          err_count      = 0;
    int          beats_checked  = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_asks      = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          send_pct_of[4] = '{0, 82, 0, 29};
    int          recv_pct_of[4] = '{0, 0, 82, 29};
    t_res        phase_res[PHASES] = '{RES_8, RES_16, RES_24, RES_32,
                                       RES_8, RES_16, RES_24, RES_32};
    logic        phase_dith[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    pcm_quantize_dither_clip u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void raise_excess(longint amount);
        if (amount > exc_pk) exc_pk = (amount > EXC_TOP) ? EXC_TOP : amount;
    endfunction

    // Clamp to the unit range and track clip count, excess and peak level
    function automatic logic track_clip(inout longint v);
        logic hit = 1'b0;
        if (v >= pk_lvl) begin
            if (v > CLIP_TOP) begin
                clip_cnt++;
                raise_excess(v - CLIP_TOP);
                v = CLIP_TOP;
                hit = 1'b1;
            end
            pk_lvl = v;
        end else if (v < -pk_lvl) begin
            if (v < CLIP_BOT) begin
                clip_cnt++;
                raise_excess(CLIP_BOT - v);
                v = CLIP_BOT;
                hit = 1'b1;
            end
            pk_lvl = -v;
        end
        return hit;
    endfunction

    // Quantize one sample and advance the shadow state
    function automatic pcm_beat_t quantize_sample(logic [31:0] smp, logic ch, logic be);
        longint      s;
        longint      o;
        longint      q;
        longint      e;
        int          eff;
        int          sb;
        logic [31:0] m32;
        logic [31:0] rnd;
        pcm_beat_t   r;
        eff = (cur_res == RES_8) ? 8 : (cur_res == RES_16) ? 16 : 24;
        sb  = FRAC_BITS + 1 - eff;
        s   = longint'($signed(smp));
        if (cur_dith) begin
            m32 = 32'((64'sd1 <<< sb) - 64'sd1);
            s = s + err_now[ch] - err_prev[ch] + err_old[ch];
            err_old[ch]  = err_prev[ch];
            err_prev[ch] = err_now[ch] / 2;
            // noise is the masked difference of two successive generator outputs
            rnd = noise_seed[ch] * LCG_MUL + LCG_ADD;
            o = s + (64'sd1 <<< (sb - 1)) + longint'({32'd0, rnd & m32})
                - longint'({32'd0, noise_seed[ch] & m32});
            noise_seed[ch] = rnd;
            r.clip = track_clip(o);
            if (r.clip) begin
                if (s > CLIP_TOP) s = CLIP_TOP;
                if (s < CLIP_BOT) s = CLIP_BOT;
            end
            q = o >>> sb;
            e = s - (q <<< sb);
            err_now[ch] = (e > ERR_TOP) ? ERR_TOP : (e < ERR_BOT) ? ERR_BOT : e;
        end else begin
            s = s + (64'sd1 <<< (FRAC_BITS - eff));
            r.clip = track_clip(s);
            q = s >>> sb;
        end
        case (cur_res)
            RES_8:   r.word = {24'd0, q[7:0] + OFFSET_8};
            RES_16:  r.word = {16'd0, q[15:0]};
            RES_24:  r.word = {8'd0, q[23:0]};
            default: r.word = {q[23:0], 8'd0};
        endcase
        r.ch     = ch;
        r.be     = be;
        r.total  = clip_cnt;
        r.peak   = pk_lvl[PEAKO_W-1:0];
        r.excess = exc_pk[EXC_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            err_count++;
        end
    endfunction

    // Mix of in-range, small, near-limit, full-scale random and extreme samples
    function automatic logic [31:0] random_sample();
        logic [31:0] v;
        int          pick;
        v    = $urandom;
        pick = $urandom_range(99);
        if (pick < 45) return {{4{v[28]}}, v[27:0]};
        if (pick < 60) return {{20{v[11]}}, v[11:0]};
        if (pick < 75) begin
            v = 32'h0FFFF800 + $urandom_range(4095);
            return ($urandom_range(1) == 0) ? v : -v;
        end
        if (pick < 90) return v;
        case ($urandom_range(5))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0FFFFFFF;
            3:       return 32'hF0000000;
            4:       return 32'h00000000;
            default: return 32'hFFFFFFFF;
        endcase
    endfunction

    // Offer one sample beat; entered and left just after a falling edge
    task automatic send_sample(logic [31:0] smp, logic ch, logic be, logic typed,
                               logic [31:0] t_word, logic t_clip);
        pcm_beat_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= smp;
        i_channel   <= ch;
        i_block_end <= be;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = quantize_sample(smp, ch, be);
        if (typed) begin
            want.word = t_word;
            want.clip = t_clip;
        end
        pending_pcm.push_back(want);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_pcm.size() != 0);
    endtask

    // Write one register, then read it back
    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", val, rd);
    endtask

    task automatic set_mode(t_res r, logic d, int send_pct, int recv_pct);
        drain_results();
        write_reg({REG_RESOLUTION, 2'b00}, {30'd0, r});
        write_reg({REG_DITHER, 2'b00}, {31'd0, d});
        cur_res        = r;
        cur_dith       = d;
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Drive the output stall and check every result beat
    initial begin : result_monitor
        pcm_beat_t want;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (pending_pcm.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got word %0h",
                             $time, o_pcm_word);
                    err_count++;
                end else begin
                    want = pending_pcm.pop_front();
                    beats_checked++;
                    check_field("pcm_word", want.word, o_pcm_word);
                    check_field("channel_out", want.ch, o_channel_out);
                    check_field("block_end_out", want.be, o_block_end_out);
                    check_field("was_clipped", want.clip, o_was_clipped);
                    check_field("clip_total", want.total, o_clip_total);
                    check_field("peak_level", want.peak, o_peak_level);
                    check_field("peak_excess", want.excess, o_peak_excess);
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        int        wait_cnt;
        directed_rows = '{
            // rounding at 16 bits: zero, small levels, then both clip limits
            '{RES_16, 1'b0, 32'h00000000, 1'b0, 1'b0, 1'b1, 32'h00000000, 1'b0},
            '{RES_16, 1'b0, 32'h00100000, 1'b1, 1'b0, 1'b1, 32'h00000080, 1'b0},
            '{RES_16, 1'b0, 32'hFFE00000, 1'b0, 1'b1, 1'b1, 32'h0000FF00, 1'b0},
            '{RES_16, 1'b0, 32'h0FFFFFFF, 1'b1, 1'b0, 1'b1, 32'h00007FFF, 1'b1},
            '{RES_16, 1'b0, 32'h7FFFFFFF, 1'b0, 1'b1, 1'b1, 32'h00007FFF, 1'b1},
            '{RES_16, 1'b0, 32'h80000000, 1'b1, 1'b0, 1'b1, 32'h00008000, 1'b1},
            '{RES_16, 1'b0, 32'hF0000000, 1'b0, 1'b0, 1'b1, 32'h00008000, 1'b0},
            // 8-bit offset binary
            '{RES_8,  1'b0, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b1, 32'h000000FF, 1'b1},
            '{RES_8,  1'b0, 32'h80000000, 1'b1, 1'b1, 1'b1, 32'h00000000, 1'b1},
            '{RES_8,  1'b0, 32'h00000000, 1'b0, 1'b0, 1'b1, 32'h00000080, 1'b0},
            // 24 and 32 bits share one quantizer
            '{RES_24, 1'b0, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b1, 32'h007FFFFF, 1'b1},
            '{RES_24, 1'b0, 32'h80000000, 1'b0, 1'b0, 1'b1, 32'h00800000, 1'b1},
            '{RES_32, 1'b0, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b1, 32'h7FFFFF00, 1'b1},
            '{RES_32, 1'b0, 32'h80000000, 1'b1, 1'b1, 1'b1, 32'h80000000, 1'b1},
            '{RES_32, 1'b0, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b1, 32'h00000000, 1'b0},
            // dither: feedback on repeated samples, both channels, clipping
            '{RES_16, 1'b1, 32'h01234567, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_16, 1'b1, 32'h01234567, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_16, 1'b1, 32'hFEDCBA98, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_8,  1'b1, 32'h0FFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_8,  1'b1, 32'h80000000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_24, 1'b1, 32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_32, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
            '{RES_32, 1'b1, 32'h00000000, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0}
        };

        // hold reset, then release it just after a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(RES_16, 1'b0, 0, 0);

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed_rows[k];
            if (row.res != cur_res || row.dith != cur_dith)
                set_mode(row.res, row.dith, 0, 0);
            send_sample(row.smp, row.ch, row.be, row.typed, row.word, row.clip);
        end

        // random phases over every width, both quantizer modes and idle patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            set_mode(phase_res[ph], phase_dith[ph], send_pct_of[ph % 4], recv_pct_of[ph % 4]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 0 && k == 30) hold_asks <= hold_asks + 1;
                if (ph == 1 && k == 40) drain_results();
                send_sample(random_sample(), 1'($urandom_range(1)),
                            ($urandom_range(7) == 0), 1'b0, 32'h0, 1'b0);
            end
        end

        // wait out the remaining results, then wait on for strays
        i_in_valid <= 1'b0;
        for (wait_cnt = 0; wait_cnt < 5000 && pending_pcm.size() != 0; wait_cnt++)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (pending_pcm.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_pcm.size());
            err_count += pending_pcm.size();
        end

        $display("Checked %0d result beats at 8/16/24/32-bit output, rounding and dither,",
                 beats_checked);
        $display("with idle and stall patterns; %0d clips, peak level %0h.",
                 clip_cnt, pk_lvl);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
rtl/pqdc_pkg.sv
rtl/pcm_quantize_dither_clip.sv
bench/tb_top.sv
